FILE: rtl/arc_pkg.sv
// Shared types and constants for the ARP resolver cache.
// Holds the request, result and table entry records and the opcode and kind codes.
// Depends on nothing; every other file of the block imports it.
package arc_pkg;

	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODULE_TAG = 2'd2;

	// Request opcodes.
	localparam logic [1:0] OP_RESOLVE = 2'd0;
	localparam logic [1:0] OP_REQUEST = 2'd1;
	localparam logic [1:0] OP_REPLY   = 2'd2;
	localparam logic [1:0] OP_CLOSE   = 2'd3;

	// Result kinds.
	localparam logic [1:0] KIND_ANSWER = 2'd0;
	localparam logic [1:0] KIND_BCAST  = 2'd1;
	localparam logic [1:0] KIND_REPLY  = 2'd2;
	localparam logic [1:0] KIND_FULL   = 2'd3;

	localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  client_id;
		logic [31:0] peer_ip;
		logic [31:0] target_ip;
		logic [47:0] peer_mac;
		logic [7:0]  rx_ifindex;
		logic [15:0] frame_tag;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  dest_client;
		logic [31:0] result_ip;
		logic [47:0] result_mac;
		logic [7:0]  result_ifindex;
	} res_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
		logic [7:0]  ifindex;
		logic [7:0]  client;
	} entry_t;

endpackage

FILE: rtl/arc_entry_mem.sv
// Table entry memory of the ARP resolver cache: one write port, one read port.
// Read data is registered, so it appears in the cycle after the address.
// Depends on arc_pkg for the entry record.
module arc_entry_mem
	import arc_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  entry_t           wdata,
	input  logic [IDX_W-1:0] raddr,
	output entry_t           rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/arc_ctrl.sv
// Sequencer of the ARP resolver cache: table scan, decision, write-back and result register.
// Keeps the valid and pending bits in flip-flops and drives the entry memory.
// Depends on arc_pkg for the request, result and entry records and codes.
module arc_ctrl
	import arc_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16,
	parameter int IDX_W         = 4,
	parameter int CNT_W         = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res,
	input  logic [31:0]      own_ip,
	input  logic [15:0]      module_tag,
	output logic             mem_we,
	output logic [IDX_W-1:0] mem_waddr,
	output entry_t           mem_wdata,
	output logic [IDX_W-1:0] mem_raddr,
	input  entry_t           mem_rdata
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DECIDE = 4'b0100,
		S_EMIT   = 4'b1000
	} state_t;

	state_t                   state_q;
	req_t                     item_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [TABLE_ENTRIES-1:0] pend_q;
	logic [CNT_W-1:0]         rd_idx_q;
	logic [IDX_W-1:0]         cmp_idx_s1;
	logic                     cmp_vld_s1;
	logic                     hit_found_q;
	logic                     hit_pend_q;
	logic [IDX_W-1:0]         hit_idx_q;
	entry_t                   hit_data_q;
	logic                     free_found_q;
	logic [IDX_W-1:0]         free_idx_q;
	res_t                     res_q;
	res_t                     out_q;
	logic                     out_valid_q;

	logic                     accept;
	logic                     tag_bad;
	logic                     rd_more;
	logic                     cur_vld;
	logic                     cur_pend;
	logic                     cur_match;
	logic                     cur_last;

	logic                     dec_we;
	logic [IDX_W-1:0]         dec_addr;
	entry_t                   dec_data;
	logic                     dec_bits_we;
	logic                     dec_vld;
	logic                     dec_pend;
	logic                     dec_emit;
	res_t                     dec_res;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign tag_bad   = (req.opcode == OP_REQUEST || req.opcode == OP_REPLY) &&
	                   (req.frame_tag != module_tag);

	assign rd_more   = (rd_idx_q < CNT_W'(TABLE_ENTRIES));
	assign mem_raddr = rd_idx_q[IDX_W-1:0];

	// Compare stage: the memory data belongs to cmp_idx_s1.
	assign cur_vld  = valid_q[cmp_idx_s1];
	assign cur_pend = pend_q[cmp_idx_s1];
	assign cur_last = (cmp_idx_s1 == IDX_W'(TABLE_ENTRIES - 1));
	always_comb begin
		if (item_q.opcode == OP_CLOSE) begin
			cur_match = cur_vld && cur_pend && (mem_rdata.client == item_q.client_id);
		end else begin
			cur_match = cur_vld && (mem_rdata.ip == item_q.peer_ip);
		end
	end

	always_comb begin
		dec_we      = 1'b0;
		dec_addr    = hit_idx_q;
		dec_data    = '{ip: item_q.peer_ip, mac: item_q.peer_mac,
		                ifindex: item_q.rx_ifindex, client: hit_data_q.client};
		dec_bits_we = 1'b0;
		dec_vld     = 1'b0;
		dec_pend    = 1'b0;
		dec_emit    = 1'b0;
		dec_res     = '{kind: KIND_ANSWER, dest_client: hit_data_q.client,
		                result_ip: item_q.peer_ip, result_mac: item_q.peer_mac,
		                result_ifindex: item_q.rx_ifindex};
		case (item_q.opcode)
			OP_RESOLVE: begin
				if (hit_found_q) begin
					if (!hit_pend_q) begin
						dec_emit = 1'b1;
						dec_res  = '{kind: KIND_ANSWER, dest_client: item_q.client_id,
						             result_ip: item_q.peer_ip, result_mac: hit_data_q.mac,
						             result_ifindex: hit_data_q.ifindex};
					end
				end else if (free_found_q) begin
					dec_we      = 1'b1;
					dec_addr    = free_idx_q;
					dec_data    = '{ip: item_q.peer_ip, mac: '0, ifindex: '0,
					                client: item_q.client_id};
					dec_bits_we = 1'b1;
					dec_vld     = 1'b1;
					dec_pend    = 1'b1;
					dec_emit    = 1'b1;
					dec_res     = '{kind: KIND_BCAST, dest_client: '0,
					                result_ip: item_q.peer_ip, result_mac: MAC_BCAST,
					                result_ifindex: '0};
				end else begin
					dec_emit = 1'b1;
					dec_res  = '{kind: KIND_FULL, dest_client: item_q.client_id,
					             result_ip: item_q.peer_ip, result_mac: '0,
					             result_ifindex: '0};
				end
			end
			OP_REQUEST: begin
				if (hit_found_q) begin
					dec_we      = 1'b1;
					dec_bits_we = 1'b1;
					dec_vld     = 1'b1;
					dec_emit    = hit_pend_q;
				end else if (item_q.target_ip == own_ip) begin
					if (free_found_q) begin
						dec_we      = 1'b1;
						dec_addr    = free_idx_q;
						dec_data    = '{ip: item_q.peer_ip, mac: item_q.peer_mac,
						                ifindex: item_q.rx_ifindex, client: '0};
						dec_bits_we = 1'b1;
						dec_vld     = 1'b1;
					end
					dec_emit = 1'b1;
					dec_res  = '{kind: KIND_REPLY, dest_client: '0,
					             result_ip: item_q.peer_ip, result_mac: item_q.peer_mac,
					             result_ifindex: item_q.rx_ifindex};
				end
			end
			OP_REPLY: begin
				if (hit_found_q && hit_pend_q) begin
					dec_we      = 1'b1;
					dec_bits_we = 1'b1;
					dec_vld     = 1'b1;
					dec_emit    = 1'b1;
				end
			end
			OP_CLOSE: begin
				if (hit_found_q) begin
					dec_bits_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign mem_we    = (state_q == S_DECIDE) && dec_we;
	assign mem_waddr = dec_addr;
	assign mem_wdata = dec_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			pend_q       <= '0;
			rd_idx_q     <= '0;
			cmp_vld_s1   <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && !tag_bad) begin
						rd_idx_q     <= '0;
						cmp_vld_s1   <= 1'b0;
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					cmp_vld_s1 <= rd_more;
					if (rd_more) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (cmp_vld_s1) begin
						if (!cur_vld && !free_found_q) begin
							free_found_q <= 1'b1;
						end
						if (cur_match) begin
							hit_found_q <= 1'b1;
							state_q     <= S_DECIDE;
						end else if (cur_last) begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					if (dec_bits_we) begin
						valid_q[dec_addr] <= dec_vld;
						pend_q[dec_addr]  <= dec_pend;
					end
					state_q <= dec_emit ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (!out_valid_q || res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (state_q == S_EMIT && (!out_valid_q || res_ready)) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
		cmp_idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (state_q == S_SCAN && cmp_vld_s1) begin
			if (!cur_vld && !free_found_q) begin
				free_idx_q <= cmp_idx_s1;
			end
			if (cur_match) begin
				hit_idx_q  <= cmp_idx_s1;
				hit_pend_q <= cur_pend;
				hit_data_q <= mem_rdata;
			end
		end
		if (state_q == S_DECIDE) begin
			res_q <= dec_res;
		end
		if (state_q == S_EMIT && (!out_valid_q || res_ready)) begin
			out_q <= res_q;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	a_pend_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & ~valid_q) == '0)
		else $error("pending bit set on an entry that is not valid");

	a_hit_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && hit_found_q) |-> valid_q[hit_idx_q])
		else $error("decision on a hit entry that is not valid");

	a_free_is_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && !hit_found_q && free_found_q) |-> !valid_q[free_idx_q])
		else $error("free slot chosen for a new entry is already valid");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (rd_idx_q <= CNT_W'(TABLE_ENTRIES)))
		else $error("scan read pointer ran past the table");

	a_emit_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && (!out_valid_q || res_ready)) |=> (out_valid_q && state_q == S_IDLE))
		else $error("result not loaded into the output register");

endmodule

FILE: rtl/arp_cache_resolver_unit.sv
// ARP resolver cache: on a hit the scan ends at the matching slot, on a miss it reads the whole
// table. A request without a result skips the emit state and frees the input sooner, and a frame
// with a wrong tag is dropped while the input stays ready. Only one request is handled at a time.
// The scan reads one table entry per cycle from the entry memory port, which sets the rate.
// A finished result waits in the output register while the next request is already taken.
// Reset (arst_n, asynchronous, active low) clears the configuration, all valid and pending bits
// and the control state at once; the entry memory itself needs no clearing.
module arp_cache_resolver_unit
	import arc_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 res_valid,
	input  logic                 res_ready,
	output res_t                 res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	// Configuration. The host's own Ethernet address is only the sender of frames built
	// elsewhere and appears in no result, so a write to that register is accepted and dropped.
	logic [31:0] own_ip_q;
	logic [15:0] module_tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q     <= '0;
			module_tag_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_OWN_IP:     own_ip_q     <= cfg_wdata[31:0];
				CFG_OWN_MAC:    ;
				CFG_MODULE_TAG: module_tag_q <= cfg_wdata[15:0];
				default:        ;
			endcase
		end
	end

	// Entry memory: IP, MAC, interface index and waiting client of each slot. The slot's valid
	// and pending bits live in flip-flops in the sequencer so that reset clears them at once.
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	entry_t           mem_rdata;

	arc_entry_mem #(
		.DEPTH (TABLE_ENTRIES),
		.IDX_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Sequencer: takes a request, scans the table from slot 0 upwards, stops on the first
	// match, remembers the lowest free slot on the way, then writes back at most one entry and
	// loads the result register.
	arc_ctrl #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.IDX_W         (IDX_W),
		.CNT_W         (CNT_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.own_ip     (own_ip_q),
		.module_tag (module_tag_q),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

endmodule
